[hw/rtl/etf_pkg.sv]
package etf_pkg;

    // Q4.28 fixed point
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 28;
    localparam int COUNT_BITS = 16;
    localparam int DIV_BITS = 24;

    localparam logic [32:0] R2_MIN = 33'd386547057;
    localparam logic [32:0] R2_MAX = 33'd4294967296;
    localparam logic [8:0] GAIN_ONE = 9'd256;

    typedef enum logic [3:0] {
        REG_KIND   = 4'd0,
        REG_ORG_RE = 4'd1,
        REG_ORG_IM = 4'd2,
        REG_STEP   = 4'd3,
        REG_JULIA  = 4'd4,
        REG_LIMIT  = 4'd5,
        REG_R2     = 4'd6,
        REG_GAINS  = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic               julia;
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
        logic [15:0]        limit;
        logic [32:0]        r2;
        logic [8:0]         gain_r;
        logic [8:0]         gain_g;
        logic [8:0]         gain_b;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } point_t;

    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        logic signed [31:0] r;
        if (v > 39'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -39'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

[hw/rtl/etf_front.sv]
module etf_front
    import etf_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  logic signed [31:0]    org_re,
    input  logic signed [31:0]    org_im,
    input  logic [30:0]           step,
    output logic                  push,
    output point_t                push_data,
    input  logic                  q_full
);
    localparam int PW = COORD_BITS + 31;
    localparam int SW = PW + 2;

    logic          busy_reg, busy_next;
    logic [PW-1:0] prod_x_reg, prod_y_reg;
    logic signed [SW-1:0] sum_re, sum_im;

    assign in_ready = !busy_reg;

    always_comb
    begin
        sum_re = SW'(org_re) + $signed({2'b00, prod_x_reg});
        sum_im = SW'(org_im) + $signed({2'b00, prod_y_reg});
        push_data.re = (sum_re > SW'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
                       (sum_re < SW'(32'sh80000000)) ? 32'sh80000000 : sum_re[31:0];
        push_data.im = (sum_im > SW'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
                       (sum_im < SW'(32'sh80000000)) ? 32'sh80000000 : sum_im[31:0];
        push = busy_reg && !q_full;
        busy_next = busy_reg;
        if (in_valid && in_ready)
            busy_next = 1'b1;
        else if (push)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_x_reg <= PW'(pixel_x) * PW'(step);
            prod_y_reg <= PW'(pixel_y) * PW'(step);
        end
    end

endmodule

[hw/rtl/etf_queue.sv]
module etf_queue
    import etf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  point_t push_data,
    output logic   full,
    input  logic   pop,
    output point_t pop_data,
    output logic   empty
);
    point_t     mem_reg [2];
    logic       wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next = push ? !wr_reg : wr_reg;
        rd_next = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

[hw/rtl/etf_div.sv]
module etf_div
    import etf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_BITS-1:0] num,
    input  logic [15:0]         den,
    output logic                done,
    output logic [7:0]          quot
);
    // restoring divider, one quotient bit a cycle
    logic                busy_reg, busy_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [DIV_BITS-1:0] q_reg, q_next;
    logic [15:0]         rem_reg, rem_next;
    logic [16:0]         rem_sh;
    logic                zero_reg;

    always_comb
    begin
        rem_sh = {rem_reg, q_reg[DIV_BITS-1]};
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        done = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 5'(DIV_BITS - 1);
            q_next = num;
            rem_next = 16'd0;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den})
            begin
                rem_next = 16'(rem_sh - {1'b0, den});
                q_next = {q_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[15:0];
                q_next = {q_reg[DIV_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end

    assign quot = zero_reg ? 8'd0 : q_reg[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        if (start)
            zero_reg <= (den == 16'd0);
    end

endmodule

[hw/rtl/etf_iter.sv]
module etf_iter
    import etf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_empty,
    input  point_t      q_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [15:0] iteration_count
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_UPD   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_COLOR = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic signed [31:0] zre_reg, zre_next, zim_reg, zim_next;
    logic signed [31:0] cre_reg, cre_next, cim_reg, cim_next;
    logic [15:0]        cnt_reg, cnt_next;
    logic [63:0]        p_rr_reg, p_ii_reg, p_ri_reg;
    logic               neg_reg;
    logic               go_reg, go_next;
    logic               ov_reg, ov_next, load;
    logic [7:0]         r_reg, g_reg, b_reg;
    logic [15:0]        cnt_out_reg;
    logic [35:0]        sre, sim;
    logic [36:0]        r2sum;
    logic [36:0]        cm;
    logic               st;
    logic signed [38:0] cross_term, nre, nim;
    logic               div_done;
    logic [7:0]         color;
    logic [16:0]        pr, pg, pb;

    etf_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(go_reg),
        .num  ({cnt_reg, 8'd0} - DIV_BITS'(cnt_reg)),
        .den  (cfg.limit),
        .done (div_done),
        .quot (color)
    );

    always_comb
    begin
        sre = p_rr_reg[63:28];
        sim = p_ii_reg[63:28];
        r2sum = {1'b0, sre} + {1'b0, sim};
        cm = p_ri_reg[63:27];
        st = |p_ri_reg[26:0];
        cross_term = neg_reg ? -$signed({2'b00, cm} + 39'(st)) : $signed({2'b00, cm});
        nre = $signed({3'b000, sre}) - $signed({3'b000, sim}) + 39'(cre_reg);
        nim = cross_term + 39'(cim_reg);
        pr = 17'(color) * 17'(cfg.gain_r);
        pg = 17'(color) * 17'(cfg.gain_g);
        pb = 17'(color) * 17'(cfg.gain_b);

        state_next = state_reg;
        zre_next = zre_reg;
        zim_next = zim_reg;
        cre_next = cre_reg;
        cim_next = cim_reg;
        cnt_next = cnt_reg;
        go_next = 1'b0;
        pop = 1'b0;
        load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    cnt_next = 16'd0;
                    if (cfg.julia)
                    begin
                        zre_next = q_data.re;
                        zim_next = q_data.im;
                        cre_next = cfg.c_re;
                        cim_next = cfg.c_im;
                    end
                    else
                    begin
                        zre_next = 32'sd0;
                        zim_next = 32'sd0;
                        cre_next = q_data.re;
                        cim_next = q_data.im;
                    end
                    if (cfg.limit == 16'd0)
                    begin
                        go_next = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
                state_next = ST_UPD;
            ST_UPD:
            begin
                if (r2sum > 37'(cfg.r2))
                begin
                    go_next = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    zre_next = sat32(nre);
                    zim_next = sat32(nim);
                    cnt_next = cnt_reg + 16'd1;
                    if (cnt_next == cfg.limit)
                    begin
                        go_next = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                        state_next = ST_MUL;
                end
            end
            ST_DIV:
                if (div_done)
                    state_next = ST_COLOR;
            ST_COLOR:
                if (!ov_reg || out_ready)
                begin
                    load = 1'b1;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
        ov_next = load ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    assign out_valid = ov_reg;
    assign red = r_reg;
    assign green = g_reg;
    assign blue = b_reg;
    assign iteration_count = cnt_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            go_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg <= go_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zre_reg <= zre_next;
        zim_reg <= zim_next;
        cre_reg <= cre_next;
        cim_reg <= cim_next;
        cnt_reg <= cnt_next;
        p_rr_reg <= 64'(mag32(zre_reg)) * 64'(mag32(zre_reg));
        p_ii_reg <= 64'(mag32(zim_reg)) * 64'(mag32(zim_reg));
        p_ri_reg <= 64'(mag32(zre_reg)) * 64'(mag32(zim_reg));
        neg_reg <= zre_reg[31] ^ zim_reg[31];
        if (load)
        begin
            r_reg <= pr[15:8];
            g_reg <= pg[15:8];
            b_reg <= pb[15:8];
            cnt_out_reg <= cnt_reg;
        end
    end

endmodule

[hw/rtl/escape_time_fractal_pixel.sv]
// Escape-time fractal pixel engine, Mandelbrot or Julia.
// Input channel (in_valid/in_ready): one word is a pixel_x/pixel_y pair.
// Output channel (out_valid/out_ready): one word carries red, green, blue
// and iteration_count for that pixel, in input order.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index picks the
// register, cfg_data the value; unknown indexes are dropped. Write only
// while no pixel is in flight.
// Path from input accept to out_valid: map the pixel to a point, run one
// z*z+c step per iteration (multiply, then add/compare), do the color
// divide, then the gain multiply into the output register; the count
// runs up to the iteration limit. The iteration loop sets the rate,
// one pixel at a time.
// The front end keeps mapping up to two pixels into a queue while the
// back end iterates.
// Reset: registers return to the Mandelbrot view with origin -2 on both
// axes, step 1/128, limit 256, radius 2; all pipes empty. If the receiver
// stalls, the finished word holds in the output register and the back end
// waits at the color step.
module escape_time_fractal_pixel
    import etf_pkg::*;
#(
    parameter int PIXEL_COORD_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [PIXEL_COORD_BITS-1:0] pixel_x,
    input  logic [PIXEL_COORD_BITS-1:0] pixel_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue,
    output logic [15:0]                 iteration_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [3:0]                  cfg_index,
    input  logic [63:0]                 cfg_data
);
    // configuration registers
    logic               kind_reg;
    logic signed [31:0] org_re_reg, org_im_reg;
    logic [30:0]        step_reg;
    logic [63:0]        julia_reg;
    logic [15:0]        limit_reg;
    logic [32:0]        r2_reg, r2_next;
    logic [8:0]         gr_reg, gg_reg, gb_reg;
    logic [8:0]         gr_next, gg_next, gb_next;
    logic               wr;

    cfg_t   cfg;
    logic   push, q_full, q_empty, pop;
    point_t push_data, pop_data;

    assign cfg_ready = 1'b1;
    assign wr = cfg_valid && cfg_ready;

    // write-side clamps on radius and gains
    always_comb
    begin
        r2_next = cfg_data[32:0];
        if (r2_next < R2_MIN)
            r2_next = R2_MIN;
        else if (r2_next > R2_MAX)
            r2_next = R2_MAX;
        gr_next = (cfg_data[26:18] > GAIN_ONE) ? GAIN_ONE : cfg_data[26:18];
        gg_next = (cfg_data[17:9] > GAIN_ONE) ? GAIN_ONE : cfg_data[17:9];
        gb_next = (cfg_data[8:0] > GAIN_ONE) ? GAIN_ONE : cfg_data[8:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= 1'b0;
            org_re_reg <= -32'sd536870912;
            org_im_reg <= -32'sd536870912;
            step_reg <= 31'd2097152;
            julia_reg <= 64'd0;
            limit_reg <= 16'd256;
            r2_reg <= 33'd1073741824;
            gr_reg <= 9'd256;
            gg_reg <= 9'd179;
            gb_reg <= 9'd128;
        end
        else if (wr)
        begin
            case (cfg_index)
                REG_KIND:   kind_reg <= cfg_data[0];
                REG_ORG_RE: org_re_reg <= cfg_data[31:0];
                REG_ORG_IM: org_im_reg <= cfg_data[31:0];
                REG_STEP:   step_reg <= cfg_data[30:0];
                REG_JULIA:  julia_reg <= cfg_data;
                REG_LIMIT:  limit_reg <= cfg_data[15:0];
                REG_R2:     r2_reg <= r2_next;
                REG_GAINS:
                begin
                    gr_reg <= gr_next;
                    gg_reg <= gg_next;
                    gb_reg <= gb_next;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.julia = kind_reg;
        cfg.c_re = julia_reg[63:32];
        cfg.c_im = julia_reg[31:0];
        cfg.limit = limit_reg;
        cfg.r2 = r2_reg;
        cfg.gain_r = gr_reg;
        cfg.gain_g = gg_reg;
        cfg.gain_b = gb_reg;
    end

    etf_front #(
        .COORD_BITS(PIXEL_COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .org_re   (org_re_reg),
        .org_im   (org_im_reg),
        .step     (step_reg),
        .push     (push),
        .push_data(push_data),
        .q_full   (q_full)
    );

    etf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (q_full),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (q_empty)
    );

    etf_iter u_iter (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_empty        (q_empty),
        .q_data         (pop_data),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .iteration_count(iteration_count)
    );

`ifndef NO_ASSERTIONS
    a_r2_range: assert property (@(posedge clk) disable iff (!rst_n)
        r2_reg >= R2_MIN && r2_reg <= R2_MAX)
        else $error("escape radius out of range");
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        gr_reg <= GAIN_ONE && gg_reg <= GAIN_ONE && gb_reg <= GAIN_ONE)
        else $error("gain above unity");
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> iteration_count <= limit_reg)
        else $error("count beyond limit");
`endif

endmodule
